[rtl/mei_pkg.sv]
package mei_pkg;

    // Field and word widths.
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 10;
    localparam int STEP_W     = 31;
    localparam int ITER_W     = 16;
    localparam int GRAY_W     = 8;
    localparam int PROD_W     = COORD_W + STEP_W;
    localparam int SUM_W      = 66;
    localparam int SQ_W       = 2 * WORD_W;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RE_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IM_START = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RE_STEP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IM_STEP  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    // Register reset values: -2.0, -2.0, 2^-7, 2^-7 in Q4.28, and 255.
    localparam logic signed [WORD_W-1:0] RST_RE_START = 32'shE000_0000;
    localparam logic signed [WORD_W-1:0] RST_IM_START = 32'shE000_0000;
    localparam logic [STEP_W-1:0]        RST_RE_STEP  = 31'h0020_0000;
    localparam logic [STEP_W-1:0]        RST_IM_STEP  = 31'h0020_0000;
    localparam logic [ITER_W-1:0]        RST_MAX_ITER = 16'd255;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [WORD_W-1:0] re_start;
        logic signed [WORD_W-1:0] im_start;
        logic [STEP_W-1:0]        re_step;
        logic [STEP_W-1:0]        im_step;
        logic [ITER_W-1:0]        max_iter;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] cre;
        logic signed [WORD_W-1:0] cim;
    } point_t;

    // Clamp a wide signed value to the signed 32-bit word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > hi)
        begin
            return hi[WORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[WORD_W-1:0];
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

[rtl/mei_ifs.sv]
// Pixel position channel.
interface mei_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [mei_pkg::COORD_W-1:0]  col;
    logic [mei_pkg::COORD_W-1:0]  row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

// Escape count result channel.
interface mei_result_if;
    logic                         valid;
    logic                         ready;
    logic [mei_pkg::ITER_W-1:0]   remaining;
    logic [mei_pkg::GRAY_W-1:0]   gray;

    modport source (output valid, output remaining, output gray, input ready);
    modport sink   (input valid, input remaining, input gray, output ready);
endinterface

[rtl/mei_cfg.sv]
module mei_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mei_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mei_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mei_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output mei_pkg::cfg_t                     cfg
);

    mei_pkg::cfg_t                   cfg_reg;
    mei_pkg::cfg_t                   cfg_next;
    logic [mei_pkg::REG_IDX_W-1:0]   idx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[mei_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register write decode; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                mei_pkg::REG_RE_START: cfg_next.re_start = pwdata[mei_pkg::WORD_W-1:0];
                mei_pkg::REG_IM_START: cfg_next.im_start = pwdata[mei_pkg::WORD_W-1:0];
                mei_pkg::REG_RE_STEP:  cfg_next.re_step  = pwdata[mei_pkg::STEP_W-1:0];
                mei_pkg::REG_IM_STEP:  cfg_next.im_step  = pwdata[mei_pkg::STEP_W-1:0];
                mei_pkg::REG_MAX_ITER: cfg_next.max_iter = pwdata[mei_pkg::ITER_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_start <= mei_pkg::RST_RE_START;
            cfg_reg.im_start <= mei_pkg::RST_IM_START;
            cfg_reg.re_step  <= mei_pkg::RST_RE_STEP;
            cfg_reg.im_step  <= mei_pkg::RST_IM_STEP;
            cfg_reg.max_iter <= mei_pkg::RST_MAX_ITER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (idx)
            mei_pkg::REG_RE_START: prdata = cfg_reg.re_start;
            mei_pkg::REG_IM_START: prdata = cfg_reg.im_start;
            mei_pkg::REG_RE_STEP:  prdata = {1'b0, cfg_reg.re_step};
            mei_pkg::REG_IM_STEP:  prdata = {1'b0, cfg_reg.im_step};
            mei_pkg::REG_MAX_ITER: prdata = {{(mei_pkg::APB_DATA_W-mei_pkg::ITER_W){1'b0}},
                                             cfg_reg.max_iter};
            default:               prdata = '0;
        endcase
    end

endmodule

[rtl/mei_front.sv]
module mei_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    mei_pixel_if.sink          pixel,
    input  mei_pkg::cfg_t      cfg,
    output logic               push_valid,
    input  logic               push_ready,
    output mei_pkg::point_t    push_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_ADD  = 3'b100
    } front_state_t;

    front_state_t                     state_reg;
    front_state_t                     state_next;
    logic [mei_pkg::COORD_W-1:0]      col_reg;
    logic [mei_pkg::COORD_W-1:0]      row_reg;
    logic [mei_pkg::COORD_W-1:0]      col_clamp;
    logic [mei_pkg::COORD_W-1:0]      row_clamp;
    logic [mei_pkg::PROD_W-1:0]       re_prod_reg;
    logic [mei_pkg::PROD_W-1:0]       im_prod_reg;
    logic signed [mei_pkg::SUM_W-1:0] re_sum;
    logic signed [mei_pkg::SUM_W-1:0] im_sum;
    logic                             accept;

    assign pixel.ready = (state_reg == F_IDLE);
    assign accept      = pixel.valid && pixel.ready;

    // Positions past the image edge fold onto the last column or row.
    always_comb
    begin
        col_clamp = pixel.col;
        row_clamp = pixel.row;
        if (int'(pixel.col) >= MAX_COLS)
        begin
            col_clamp = mei_pkg::COORD_W'(MAX_COLS - 1);
        end
        if (int'(pixel.row) >= MAX_ROWS)
        begin
            row_clamp = mei_pkg::COORD_W'(MAX_ROWS - 1);
        end
    end

    // Start point plus exact offset, then saturate to a word.
    always_comb
    begin
        re_sum = mei_pkg::SUM_W'(cfg.re_start) + $signed(mei_pkg::SUM_W'(re_prod_reg));
        im_sum = mei_pkg::SUM_W'(cfg.im_start) + $signed(mei_pkg::SUM_W'(im_prod_reg));
        push_data.cre = mei_pkg::sat_word(re_sum);
        push_data.cim = mei_pkg::sat_word(im_sum);
    end

    assign push_valid = (state_reg == F_ADD);

    // Sequencer: take a beat, multiply, then hand the point to the queue.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:   state_next = F_ADD;
            F_ADD:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Position and offset products.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg <= col_clamp;
            row_reg <= row_clamp;
        end
        if (state_reg == F_MUL)
        begin
            re_prod_reg <= mei_pkg::PROD_W'(col_reg) * mei_pkg::PROD_W'(cfg.re_step);
            im_prod_reg <= mei_pkg::PROD_W'(row_reg) * mei_pkg::PROD_W'(cfg.im_step);
        end
    end

endmodule

[rtl/mei_queue.sv]
module mei_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mei_pkg::point_t    push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mei_pkg::point_t    pop_data
);

    mei_pkg::point_t              entry_reg [mei_pkg::QUEUE_DEPTH];
    logic [mei_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mei_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mei_pkg::QPTR_W:0]     count_reg;
    logic [mei_pkg::QPTR_W:0]     count_next;
    logic                         push;
    logic                         pop;

    assign push_ready = (count_reg != (mei_pkg::QPTR_W + 1)'(mei_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/mei_back.sv]
module mei_back #(
    parameter int FRAC_BITS = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  mei_pkg::point_t    pop_data,
    input  mei_pkg::cfg_t      cfg,
    mei_result_if.source       result
);

    typedef enum logic [2:0] {
        B_IDLE   = 3'b001,
        B_CHECK  = 3'b010,
        B_UPDATE = 3'b100
    } back_state_t;

    // Escape bound 2.0 in the working fraction format.
    localparam logic [63:0] LIMIT = 64'd2 << FRAC_BITS;

    back_state_t                      state_reg;
    back_state_t                      state_next;
    logic signed [mei_pkg::WORD_W-1:0] x_reg;
    logic signed [mei_pkg::WORD_W-1:0] y_reg;
    logic signed [mei_pkg::WORD_W-1:0] cre_reg;
    logic signed [mei_pkg::WORD_W-1:0] cim_reg;
    logic signed [mei_pkg::SQ_W-1:0]   xx_reg;
    logic signed [mei_pkg::SQ_W-1:0]   yy_reg;
    logic signed [mei_pkg::SQ_W-1:0]   xy_reg;
    logic [mei_pkg::ITER_W-1:0]        cnt_reg;
    logic [mei_pkg::ITER_W-1:0]        out_cnt_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [mei_pkg::WORD_W:0]   x_ext;
    logic signed [mei_pkg::WORD_W:0]   y_ext;
    logic [mei_pkg::WORD_W:0]          x_abs;
    logic [mei_pkg::WORD_W:0]          y_abs;
    logic                              escaped;
    logic                              stop;
    logic                              out_free;
    logic                              load_out;
    logic                              take;
    logic signed [mei_pkg::SUM_W-1:0]  nx_sum;
    logic signed [mei_pkg::SUM_W-1:0]  ny_sum;

    assign pop_ready = (state_reg == B_IDLE);
    assign take      = pop_valid && pop_ready;

    // Escape test on the magnitudes of both components.
    always_comb
    begin
        x_ext   = (mei_pkg::WORD_W + 1)'(x_reg);
        y_ext   = (mei_pkg::WORD_W + 1)'(y_reg);
        x_abs   = x_reg[mei_pkg::WORD_W-1] ? -x_ext : x_ext;
        y_abs   = y_reg[mei_pkg::WORD_W-1] ? -y_ext : y_ext;
        escaped = (64'(x_abs) >= LIMIT) || (64'(y_abs) >= LIMIT);
        stop    = (cnt_reg == '0) || escaped;
    end

    assign out_free = !out_valid_reg || result.ready;
    assign load_out = (state_reg == B_CHECK) && stop && out_free;

    // z*z + c from the registered products, floored and saturated.
    always_comb
    begin
        nx_sum = mei_pkg::SUM_W'(xx_reg >>> FRAC_BITS) - mei_pkg::SUM_W'(yy_reg >>> FRAC_BITS)
                 + mei_pkg::SUM_W'(cre_reg);
        ny_sum = mei_pkg::SUM_W'(xy_reg >>> (FRAC_BITS - 1)) + mei_pkg::SUM_W'(cim_reg);
    end

    // Iteration sequencer: check, multiply, update, repeat.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (!stop)
                begin
                    state_next = B_UPDATE;
                end
                else if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_UPDATE: state_next = B_CHECK;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: load a new point, form products, then step z and the counter.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cre_reg <= pop_data.cre;
            cim_reg <= pop_data.cim;
            x_reg   <= '0;
            y_reg   <= '0;
            cnt_reg <= cfg.max_iter;
        end
        if ((state_reg == B_CHECK) && !stop)
        begin
            xx_reg <= mei_pkg::SQ_W'(x_reg) * mei_pkg::SQ_W'(x_reg);
            yy_reg <= mei_pkg::SQ_W'(y_reg) * mei_pkg::SQ_W'(y_reg);
            xy_reg <= mei_pkg::SQ_W'(x_reg) * mei_pkg::SQ_W'(y_reg);
        end
        if (state_reg == B_UPDATE)
        begin
            x_reg   <= mei_pkg::sat_word(nx_sum);
            y_reg   <= mei_pkg::sat_word(ny_sum);
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (load_out)
        begin
            out_cnt_reg <= cnt_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.remaining = out_cnt_reg;
    assign result.gray      = out_cnt_reg[mei_pkg::GRAY_W-1:0];

endmodule

[rtl/mandelbrot_escape_iterator_top.sv]
// The pixel rate is set by the back end's multiply and update step for each iteration,
// which runs at most max_iter times per pixel.
// A two-entry queue lets the front prepare the next point while the back end iterates.
// rst_n (asynchronous, active low) clears all control state; the registers return to
// re_start = im_start = -2.0, re_step = im_step = 2^-7 and max_iter = 255.
module mandelbrot_escape_iterator_top #(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 1024,
    parameter int FRAC_BITS = 28
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mei_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mei_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mei_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    mei_pixel_if.sink                         pixel,
    mei_result_if.source                      result
);

    mei_pkg::cfg_t     cfg;
    logic              q_push_valid;
    logic              q_push_ready;
    mei_pkg::point_t   q_push_data;
    logic              q_pop_valid;
    logic              q_pop_ready;
    mei_pkg::point_t   q_pop_data;

    mei_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mei_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    mei_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    mei_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .cfg       (cfg),
        .result    (result)
    );

    // A point pushed into the queue is visible to the back end next cycle.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && q_push_ready |=> q_pop_valid)
        else $error("queue empty right after a push");

    // The front end is busy in the cycle after it takes a pixel beat.
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.ready |=> !pixel.ready)
        else $error("front end ready again right after accepting a beat");

    // The back end works on one point at a time.
    a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop_valid && q_pop_ready |=> !q_pop_ready)
        else $error("back end took a second point while iterating");

endmodule
